[rtl/core/pnr_pkg.sv]
// pnr_pkg: shared types and constants of the pepper noise repair filter
// used by pnr_front, pnr_back and the core top level, depends on nothing
`default_nettype none

package pnr_pkg;

    localparam int unsigned PIX_W = 8;
    localparam int unsigned WIDTH_CFG_W = 11;
    localparam int unsigned HEIGHT_CFG_W = 13;
    localparam int unsigned THR_W = 11;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned ROW_W = 13;
    localparam int unsigned OROW_W = 12;
    localparam int unsigned WT_W = 16;
    localparam int unsigned SUM_W = 24;
    localparam int unsigned DIV_W = 26;
    localparam int unsigned WIN_CELLS = 25;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOISE_THRESHOLD = 2'd2;

    localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET = 11'd640;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [THR_W-1:0] THR_RESET = 11'd153;
    localparam logic [HEIGHT_CFG_W-1:0] MAX_HEIGHT = 13'd4096;

    // inverse distance weights, unsigned q1.12, row by row
    localparam logic [12:0] WTAB [WIN_CELLS] = '{
        13'd1448, 13'd1832, 13'd2048, 13'd1832, 13'd1448,
        13'd1832, 13'd2896, 13'd4096, 13'd2896, 13'd1832,
        13'd2048, 13'd4096, 13'd0,    13'd4096, 13'd2048,
        13'd1832, 13'd2896, 13'd4096, 13'd2896, 13'd1832,
        13'd1448, 13'd1832, 13'd2048, 13'd1832, 13'd1448
    };

    typedef struct packed {
        logic       has_out;
        logic       cand;
        logic [4:0] row_ok;
        logic [4:0] col_ok;
        logic       last;
        logic [1:0] wr_slot;
        logic [1:0] wb_slot;
    } pnr_ctl_t;

    localparam int unsigned CTL_W = $bits(pnr_ctl_t);

endpackage

`default_nettype wire

[rtl/core/pnr_fifo.sv]
// pnr_fifo: two-entry queue between the front and back parts
// generic data width, no package dependency
`default_nettype none

module pnr_fifo #(
    parameter int unsigned DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] din,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      dout,
    output logic                   empty
);
    logic [DATA_W-1:0] mem_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("queue written while full");
    a_pop_data: assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

[rtl/core/pnr_front.sv]
// pnr_front: accepts input beats, tracks frame position and classifies each item
// depends on pnr_pkg
`default_nettype none

module pnr_front #(
    parameter int unsigned MAX_WIDTH = 1024,
    localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,
    input  wire logic                               s_tuser,
    input  wire logic [pnr_pkg::WIDTH_CFG_W-1:0]    cfg_width,
    input  wire logic [pnr_pkg::HEIGHT_CFG_W-1:0]   cfg_height,
    input  wire logic                               q_full,
    output logic                                    q_push,
    output pnr_pkg::pnr_ctl_t                       q_ctl,
    output logic [7:0]                              q_pix,
    output logic [CW-1:0]                           q_col,
    output logic [CW-1:0]                           q_wb_col
);
    import pnr_pkg::*;

    localparam int unsigned WW = CW + 1;

    logic [ROW_W-1:0]        row_reg;
    logic [CW-1:0]           col_reg;
    logic [OROW_W-1:0]       orow_reg;
    logic [CW-1:0]           ocol_reg;
    logic [WW-1:0]           fw_reg;
    logic [HEIGHT_CFG_W-1:0] fh_reg;

    logic [WW-1:0]           sat_w;
    logic [HEIGHT_CFG_W-1:0] sat_h;
    logic [WW-1:0]           fw;
    logic [HEIGHT_CFG_W-1:0] fh;
    logic                    start;
    logic                    in_frame;
    logic                    has_out;
    logic                    last;
    logic                    cand;
    logic [4:0]              row_ok;
    logic [4:0]              col_ok;
    logic                    accept;

    always_comb begin
        if (cfg_width < WIDTH_CFG_W'(3)) begin
            sat_w = WW'(3);
        end else if (32'(cfg_width) > MAX_WIDTH) begin
            sat_w = WW'(MAX_WIDTH);
        end else begin
            sat_w = WW'(cfg_width);
        end
        if (cfg_height < HEIGHT_CFG_W'(3)) begin
            sat_h = HEIGHT_CFG_W'(3);
        end else if (cfg_height > MAX_HEIGHT) begin
            sat_h = MAX_HEIGHT;
        end else begin
            sat_h = cfg_height;
        end
    end

    assign start    = (row_reg == '0) && (col_reg == '0);
    assign fw       = start ? sat_w : fw_reg;
    assign fh       = start ? sat_h : fh_reg;
    assign in_frame = (row_reg < fh);
    assign has_out  = (row_reg > ROW_W'(2)) ||
                      ((row_reg == ROW_W'(2)) && (col_reg >= CW'(2)));
    assign last     = ({1'b0, orow_reg} == fh - HEIGHT_CFG_W'(1)) &&
                      ({1'b0, ocol_reg} == fw - WW'(1));
    assign cand     = (orow_reg != '0) && ({1'b0, orow_reg} + HEIGHT_CFG_W'(1) < fh) &&
                      (ocol_reg != '0) && ({1'b0, ocol_reg} + WW'(1) < fw);

    always_comb begin
        logic [HEIGHT_CFG_W:0] rsum;
        logic [WW:0]           csum;
        for (int r = 0; r < 5; r++) begin
            rsum = {2'b0, orow_reg} + (HEIGHT_CFG_W+1)'(r);
            csum = {2'b0, ocol_reg} + (WW+1)'(r);
            row_ok[r] = (rsum >= (HEIGHT_CFG_W+1)'(2)) &&
                        (rsum < {1'b0, fh} + (HEIGHT_CFG_W+1)'(2));
            col_ok[r] = (csum >= (WW+1)'(2)) && (csum < {1'b0, fw} + (WW+1)'(2));
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    // padding inside the frame carries no pixel and is dropped
    assign q_push   = accept && !(s_tuser && in_frame);

    assign q_pix    = in_frame ? s_tdata : 8'd0;
    assign q_col    = col_reg;
    assign q_wb_col = ocol_reg;

    always_comb begin
        q_ctl         = '0;
        q_ctl.has_out = has_out;
        q_ctl.cand    = cand;
        q_ctl.row_ok  = row_ok;
        q_ctl.col_ok  = col_ok;
        q_ctl.last    = last;
        q_ctl.wr_slot = row_reg[1:0];
        q_ctl.wb_slot = orow_reg[1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            orow_reg <= '0;
            ocol_reg <= '0;
            fw_reg   <= WW'(640);
            fh_reg   <= HEIGHT_RESET;
        end else if (q_push) begin
            if (start) begin
                fw_reg <= sat_w;
                fh_reg <= sat_h;
            end
            if ({1'b0, col_reg} + WW'(1) >= fw) begin
                col_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
            if (has_out) begin
                if (last) begin
                    row_reg  <= '0;
                    col_reg  <= '0;
                    orow_reg <= '0;
                    ocol_reg <= '0;
                end else if ({1'b0, ocol_reg} + WW'(1) >= fw) begin
                    ocol_reg <= '0;
                    orow_reg <= orow_reg + OROW_W'(1);
                end else begin
                    ocol_reg <= ocol_reg + CW'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/pnr_back.sv]
// pnr_back: line stores, 5x5 window, weighted sum and iterative divider, output register
// depends on pnr_pkg
`default_nettype none

module pnr_back #(
    parameter int unsigned MAX_WIDTH = 1024,
    localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_empty,
    output logic                             q_pop,
    input  wire pnr_pkg::pnr_ctl_t           q_ctl,
    input  wire logic [7:0]                  q_pix,
    input  wire logic [CW-1:0]               q_col,
    input  wire logic [CW-1:0]               q_wb_col,
    input  wire logic [pnr_pkg::THR_W-1:0]   thr,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [7:0]                       m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast
);
    import pnr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SHIFT, ST_CHECK, ST_ACC, ST_PREP, ST_DIV, ST_WB, ST_EMIT
    } state_t;

    state_t               state_reg;
    pnr_ctl_t             ctl_reg;
    logic [7:0]           pix_reg;
    logic [CW-1:0]        col_reg;
    logic [CW-1:0]        wbcol_reg;
    logic [24:0][7:0]     win_reg;
    logic [4:0]           idx_reg;
    logic [2:0]           r_reg;
    logic [2:0]           p_reg;
    logic [SUM_W-1:0]     s_reg;
    logic [WT_W-1:0]      wt_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dsh_reg;
    logic [8:0]           q_reg;
    logic [3:0]           cnt_reg;
    logic [7:0]           res_pix_reg;
    logic                 res_rep_reg;
    logic                 m_tvalid_reg;
    logic [7:0]           m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 m_tlast_reg;

    logic [3:0][7:0]      rd_data;
    logic [3:0]           bank_we;
    logic [CW-1:0]        bank_waddr;
    logic [7:0]           bank_wdata;
    logic [7:0]           q8;
    logic [11:0]          nsum;
    logic [7:0]           tap_pix;
    logic                 incl;
    logic [20:0]          prod;

    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign q8         = q_reg[8] ? 8'hFF : q_reg[7:0];
    assign bank_waddr = (state_reg == ST_WB) ? wbcol_reg : col_reg;
    assign bank_wdata = (state_reg == ST_WB) ? q8 : pix_reg;

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            bank_we[b] = ((state_reg == ST_SHIFT) && (ctl_reg.wr_slot == 2'(b))) ||
                         ((state_reg == ST_WB) && (ctl_reg.wb_slot == 2'(b)));
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [7:0] mem [MAX_WIDTH];
        logic [7:0] rd_q_reg;
        always_ff @(posedge aclk) begin
            if (bank_we[g]) begin
                mem[bank_waddr] <= bank_wdata;
            end
            if (q_pop) begin
                rd_q_reg <= mem[q_col];
            end
        end
        assign rd_data[g] = rd_q_reg;
    end

    always_comb begin
        nsum = 12'(win_reg[6]) + 12'(win_reg[7]) + 12'(win_reg[8]) +
               12'(win_reg[11]) + 12'(win_reg[12]) + 12'(win_reg[13]) +
               12'(win_reg[16]) + 12'(win_reg[17]) + 12'(win_reg[18]);
    end

    assign tap_pix = win_reg[idx_reg];
    assign incl    = ctl_reg.row_ok[r_reg] && ctl_reg.col_ok[p_reg] && (tap_pix != 8'd0);
    assign prod    = tap_pix * WTAB[idx_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            win_reg      <= '0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        ctl_reg   <= q_ctl;
                        pix_reg   <= q_pix;
                        col_reg   <= q_col;
                        wbcol_reg <= q_wb_col;
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    for (int r = 0; r < 5; r++) begin
                        for (int p = 0; p < 4; p++) begin
                            win_reg[r*5+p] <= win_reg[r*5+p+1];
                        end
                    end
                    for (int r = 0; r < 4; r++) begin
                        win_reg[r*5+4] <= rd_data[2'(ctl_reg.wr_slot + 2'(r))];
                    end
                    win_reg[24] <= pix_reg;
                    state_reg   <= ctl_reg.has_out ? ST_CHECK : ST_IDLE;
                end
                ST_CHECK: begin
                    res_pix_reg <= win_reg[12];
                    res_rep_reg <= 1'b0;
                    if ((win_reg[12] == 8'd0) && ctl_reg.cand && (nsum > 12'(thr))) begin
                        idx_reg   <= '0;
                        r_reg     <= '0;
                        p_reg     <= '0;
                        s_reg     <= '0;
                        wt_reg    <= '0;
                        state_reg <= ST_ACC;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_ACC: begin
                    if (incl) begin
                        s_reg  <= s_reg + SUM_W'(prod);
                        wt_reg <= wt_reg + WT_W'(WTAB[idx_reg]);
                    end
                    idx_reg <= idx_reg + 5'd1;
                    if (p_reg == 3'd4) begin
                        p_reg <= '0;
                        r_reg <= r_reg + 3'd1;
                    end else begin
                        p_reg <= p_reg + 3'd1;
                    end
                    if (idx_reg == 5'(WIN_CELLS - 1)) begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    rem_reg   <= DIV_W'({s_reg, 1'b0}) + DIV_W'(wt_reg);
                    dsh_reg   <= DIV_W'({wt_reg, 9'b0});
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= (wt_reg == '0) ? ST_EMIT : ST_DIV;
                end
                ST_DIV: begin
                    if (rem_reg >= dsh_reg) begin
                        rem_reg <= rem_reg - dsh_reg;
                        q_reg   <= {q_reg[7:0], 1'b1};
                    end else begin
                        q_reg   <= {q_reg[7:0], 1'b0};
                    end
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd8) begin
                        state_reg <= ST_WB;
                    end
                end
                ST_WB: begin
                    win_reg[12] <= q8;
                    res_pix_reg <= q8;
                    res_rep_reg <= 1'b1;
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_pix_reg;
                        m_tuser_reg  <= res_rep_reg;
                        m_tlast_reg  <= ctl_reg.last;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_quot_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB) |-> !q_reg[8])
        else $error("rounded mean above full scale");
    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |=> (state_reg == ST_DIV) || (state_reg == ST_WB))
        else $error("divider left early");
    a_emit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> ctl_reg.has_out)
        else $error("result for an item that has none");

endmodule

`default_nettype wire

[rtl/core/pepper_noise_repair_filter_core.sv]
// pepper_noise_repair_filter_core: top level, configuration registers and part wiring
// depends on pnr_pkg, pnr_front, pnr_fifo, pnr_back
//
//   channel  direction  beat contents
//   s_       in         tdata: pixel_in[7:0]; tuser: is_padding
//   m_       out        tdata: pixel_out[7:0]; tuser: was_repaired; tlast: last_of_frame
//   cfg_     in         write enable, register index, data
//
// in the back part a plain pixel is shifted in, checked and emitted; a repaired one also
// takes the weighted sum, one cell a cycle, and a restoring division; items with no
// result are only shifted in. results start two rows plus two pixels after the frame's
// first pixel. reset is synchronous, active low; line stores come up unwritten.
// a two-entry queue lets input beats in while the back part or the output stalls.
`default_nettype none

module pepper_noise_repair_filter_core #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // pixel_in
    input  wire logic                              s_tuser,   // is_padding
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata,   // pixel_out
    output logic                                   m_tuser,   // was_repaired
    output logic                                   m_tlast,
    input  wire logic                              cfg_wr_en,
    input  wire logic [pnr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [pnr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pnr_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned QW = CTL_W + 8 + 2 * CW;

    logic [WIDTH_CFG_W-1:0]  width_reg;
    logic [HEIGHT_CFG_W-1:0] height_reg;
    logic [THR_W-1:0]        thr_reg;

    logic                    q_push;
    logic                    q_pop;
    logic                    q_full;
    logic                    q_empty;
    pnr_ctl_t                f_ctl;
    logic [7:0]              f_pix;
    logic [CW-1:0]           f_col;
    logic [CW-1:0]           f_wb_col;
    pnr_ctl_t                b_ctl;
    logic [7:0]              b_pix;
    logic [CW-1:0]           b_col;
    logic [CW-1:0]           b_wb_col;
    logic [QW-1:0]           q_din;
    logic [QW-1:0]           q_dout;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            thr_reg    <= THR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:     width_reg  <= cfg_data[WIDTH_CFG_W-1:0];
                CFG_IMAGE_HEIGHT:    height_reg <= cfg_data;
                CFG_NOISE_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    pnr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_ctl      (f_ctl),
        .q_pix      (f_pix),
        .q_col      (f_col),
        .q_wb_col   (f_wb_col)
    );

    assign q_din = {f_ctl, f_pix, f_col, f_wb_col};
    assign {b_ctl, b_pix, b_col, b_wb_col} = q_dout;

    pnr_fifo #(.DATA_W(QW)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    pnr_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_ctl    (b_ctl),
        .q_pix    (b_pix),
        .q_col    (b_col),
        .q_wb_col (b_wb_col),
        .thr      (thr_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[sim/tb_top.sv]
// tb_top: self-checking testbench of pepper_noise_repair_filter_core
// holds a scoreboard class with its own 5x5 repair predictor; depends on pnr_pkg and the rtl
`default_nettype none

class pnr_scoreboard;
    int unsigned cfg_w = 640;
    int unsigned cfg_h = 480;
    int unsigned cfg_thr = 153;
    bit [7:0]    line_mem [4*1024];
    bit [7:0]    win [25];
    int unsigned row_n, col_n, out_n;
    int unsigned frame_w = 640;
    int unsigned frame_h = 480;
    bit [7:0]    exp_pix [$];
    bit          exp_rep [$];
    bit          exp_last [$];
    int          errors;

    function void write_reg(logic [pnr_pkg::CFG_INDEX_W-1:0] idx, int unsigned val);
        case (idx)
            pnr_pkg::CFG_IMAGE_WIDTH:     cfg_w = val & 11'h7ff;
            pnr_pkg::CFG_IMAGE_HEIGHT:    cfg_h = val & 13'h1fff;
            pnr_pkg::CFG_NOISE_THRESHOLD: cfg_thr = val & 11'h7ff;
            default: ;
        endcase
    endfunction

    function int unsigned frame_w_next();
        return cfg_w < 3 ? 3 : (cfg_w > 1024 ? 1024 : cfg_w);
    endfunction

    function int unsigned frame_h_next();
        return cfg_h < 3 ? 3 : (cfg_h > 4096 ? 4096 : cfg_h);
    endfunction

    // one accepted input beat; queues the pixel it releases, if any
    function void note_beat(bit [7:0] px, bit pad);
        int unsigned n, total, a, b, k, i, j, centre, nsum, s, wt, v;
        bit [7:0]    col [5];
        bit          rep;
        rep = 0;
        if (row_n == 0 && col_n == 0) begin
            if (pad) return;
            frame_w = frame_w_next();
            frame_h = frame_h_next();
        end
        total = frame_w * frame_h;
        n = row_n * frame_w + col_n;
        if (n < total && pad) return;
        if (n >= total) px = 0;
        a = row_n;
        b = col_n;
        for (int r = 0; r < 4; r++) col[r] = line_mem[((a + r) % 4) * 1024 + b];
        col[4] = px;
        line_mem[(a % 4) * 1024 + b] = px;
        for (int r = 0; r < 5; r++) begin
            for (int p = 0; p < 4; p++) win[r*5+p] = win[r*5+p+1];
            win[r*5+4] = col[r];
        end
        col_n++;
        if (col_n >= frame_w) begin
            col_n = 0;
            row_n++;
        end
        if (n < 2 * frame_w + 2) return;
        k = out_n;
        i = k / frame_w;
        j = k % frame_w;
        centre = win[12];
        if (centre == 0 && i >= 1 && i + 1 < frame_h && j >= 1 && j + 1 < frame_w) begin
            nsum = 0;
            for (int r = 1; r < 4; r++)
                for (int p = 1; p < 4; p++) nsum += win[r*5+p];
            if (nsum > cfg_thr) begin
                s = 0;
                wt = 0;
                for (int r = 0; r < 5; r++) begin
                    if (i + r < 2 || i + r - 2 >= frame_h) continue;
                    for (int p = 0; p < 5; p++) begin
                        v = win[r*5+p];
                        if (j + p < 2 || j + p - 2 >= frame_w || v == 0) continue;
                        wt += pnr_pkg::WTAB[r*5+p];
                        s += v * pnr_pkg::WTAB[r*5+p];
                    end
                end
                if (wt != 0) begin
                    centre = (2 * s + wt) / (2 * wt);
                    if (centre > 255) centre = 255;
                    win[12] = centre[7:0];
                    line_mem[(i % 4) * 1024 + j] = centre[7:0];
                    rep = 1;
                end
            end
        end
        exp_pix.push_back(centre[7:0]);
        exp_rep.push_back(rep);
        exp_last.push_back(k + 1 == total);
        if (k + 1 == total) begin
            row_n = 0;
            col_n = 0;
            out_n = 0;
        end else begin
            out_n = k + 1;
        end
    endfunction

    function void check_beat(bit [7:0] px, bit rep, bit last);
        if (exp_pix.size() == 0) begin
            $display("%0t: unexpected beat pixel %0d repaired %0d last %0d", $time, px, rep, last);
            errors++;
            return;
        end
        if (px !== exp_pix[0])
            $display("%0t: pixel_out expected %0d actual %0d", $time, exp_pix[0], px);
        if (rep !== exp_rep[0])
            $display("%0t: was_repaired expected %0d actual %0d", $time, exp_rep[0], rep);
        if (last !== exp_last[0])
            $display("%0t: last_of_frame expected %0d actual %0d", $time, exp_last[0], last);
        if (px !== exp_pix[0] || rep !== exp_rep[0] || last !== exp_last[0]) errors++;
        void'(exp_pix.pop_front());
        void'(exp_rep.pop_front());
        void'(exp_last.pop_front());
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [7:0] s_tdata = 0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [7:0] m_tdata;
    logic m_tuser;
    logic m_tlast;
    logic cfg_wr_en = 0;
    logic [pnr_pkg::CFG_INDEX_W-1:0] cfg_index = pnr_pkg::CFG_IMAGE_WIDTH;
    logic [pnr_pkg::CFG_DATA_W-1:0] cfg_data = 0;

    pnr_scoreboard sb = new();
    int unsigned cycles = 0;
    int unsigned stall_left = 0;
    int unsigned beats_sent = 0;
    bit calm = 0;

    pepper_noise_repair_filter_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("tb_top failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 0;
        end else if (!calm && aresetn && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser, m_tlast);

    task automatic send_beat(bit [7:0] px, bit pad);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= px;
        s_tuser <= pad;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(px, pad);
        beats_sent++;
    endtask

    task automatic write_reg(logic [pnr_pkg::CFG_INDEX_W-1:0] idx, int unsigned val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= pnr_pkg::CFG_DATA_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.write_reg(idx, val);
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.exp_pix.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned thr);
        write_reg(pnr_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(pnr_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(pnr_pkg::CFG_NOISE_THRESHOLD, thr);
    endtask

    // pixels of one frame, stray padding inside it, then the drain beats
    task automatic run_frame(int unsigned zero_pct);
        bit [7:0] px;
        for (int unsigned q = 0; q < sb.frame_w_next() * sb.frame_h_next(); q++) begin
            if ($urandom_range(0, 19) == 0) send_beat(8'($urandom_range(0, 255)), 1'b1);
            if ($urandom_range(0, 99) < zero_pct) px = 0;
            else if ($urandom_range(0, 1)) px = 8'($urandom_range(120, 255));
            else px = 8'($urandom_range(0, 255));
            send_beat(px, 0);
        end
        for (int unsigned q = 0; q < 2 * sb.frame_w + 2; q++)
            send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        wait_drained();
    endtask

    task automatic directed_frame(bit [7:0] p0, bit [7:0] p1, bit [7:0] p2, bit [7:0] p3,
                                  bit [7:0] p5, bit [7:0] p6, bit [7:0] p7, bit [7:0] p8);
        bit [7:0] pix [9];
        pix = '{p0, p1, p2, p3, 8'd0, p5, p6, p7, p8};
        for (int q = 0; q < 9; q++) send_beat(pix[q], 0);
        for (int q = 0; q < 8; q++) send_beat(8'hff, q[0]);
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        set_frame(3, 3, 153);
        send_beat(8'h00, 1);
        directed_frame(255, 255, 255, 255, 255, 255, 255, 1);
        directed_frame(0, 0, 0, 0, 0, 0, 0, 0);
        write_reg(pnr_pkg::CFG_NOISE_THRESHOLD, 2047);
        directed_frame(255, 255, 255, 255, 255, 255, 255, 255);
        write_reg(pnr_pkg::CFG_NOISE_THRESHOLD, 0);
        directed_frame(0, 0, 0, 0, 1, 0, 0, 0);

        while (beats_sent < 300) begin
            set_frame($urandom_range(3, 9), $urandom_range(3, 7),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047)
                                                : $urandom_range(0, 700));
            run_frame($urandom_range(10, 60));
        end

        set_frame(0, 0, 0);
        run_frame(30);
        set_frame(2, 1, 300);
        run_frame(5);
        set_frame(5, 4096, 2040);
        write_reg(pnr_pkg::CFG_IMAGE_HEIGHT, 3);
        run_frame(40);

        calm = 1;
        repeat (3) begin
            set_frame($urandom_range(3, 8), $urandom_range(3, 6), $urandom_range(0, 500));
            run_frame(40);
        end

        if (sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
